[rtl/alc_pkg.sv]
package alc_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIRST  = 2'd1;
    localparam logic [1:0] OP_NEXT   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_NOCUR = 2'd3;

    typedef struct packed {
        logic load;     // take the appended word
        logic shift;    // take the upper neighbor's word
    } cell_ctl_t;

endpackage

[rtl/alc_cell.sv]
module alc_cell #(
    parameter int WORD_BITS = alc_pkg::WORD_BITS_DEF
) (
    input  logic                  clk,
    input  alc_pkg::cell_ctl_t    ctl,
    input  logic [WORD_BITS-1:0]  data_in,
    input  logic [WORD_BITS-1:0]  upper,
    output logic [WORD_BITS-1:0]  q
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.shift)
        begin
            word_next = upper;
        end
        else if (ctl.load)
        begin
            word_next = data_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

[rtl/array_list_with_cursor.sv]
// Ordered list of up to DEPTH signed words with a read cursor.
// Requests come in on start with operation and data_in; one is taken at
// every clock edge where start is high and busy is low. busy never rises,
// so a request may be issued in every cycle.
// Operations: insert appends data_in, first reads entry 0 and places the
// cursor there, next advances the cursor and reads that entry, remove
// takes out the entry at the cursor, closes the gap and steps the cursor
// back.
// Each request gives one result on data_out, status and entry_count,
// marked by done for exactly one cycle, the cycle after the request.
// Throughput is 1 request per cycle; every operation, remove included,
// completes without a stall because each entry sits in its own cell and
// all cells behind the cursor shift down at the same edge.
// The receiver has no way to stall; results must be taken when done is high.
// Reset empties the list and clears the cursor to no position; the stored
// words themselves are not cleared and are never read before written.
module array_list_with_cursor #(
    parameter int DEPTH     = alc_pkg::DEPTH_DEF,
    parameter int WORD_BITS = alc_pkg::WORD_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int IDX_W    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            operation,
    input  logic signed [WORD_BITS-1:0] data_in,
    output logic                  done,
    output logic signed [WORD_BITS-1:0] data_out,
    output logic [1:0]            status,
    output logic [CNT_W-1:0]      entry_count
);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]     cur_idx_reg, cur_idx_next;
    logic                 done_reg;
    logic [WORD_BITS-1:0] data_out_reg, data_out_next;
    logic [1:0]           status_reg, status_next;

    logic                 req;
    logic                 ins_ok;
    logic                 rem_ok;
    logic [CNT_W-1:0]     cur_plus;
    logic [IDX_W-1:0]     rd_idx;
    logic [WORD_BITS-1:0] rd_word;

    logic [WORD_BITS-1:0] cell_q [DEPTH];

    assign busy = 1'b0;
    assign req  = start && !busy;

    // position after advancing; zero when no position is held
    assign cur_plus = cur_valid_reg ? (CNT_W'(cur_idx_reg) + CNT_W'(1)) : '0;

    assign ins_ok = req && (operation == alc_pkg::OP_INSERT)
                    && (count_reg < CNT_W'(DEPTH));
    assign rem_ok = req && (operation == alc_pkg::OP_REMOVE) && cur_valid_reg;

    always_comb
    begin
        unique case (operation)
            alc_pkg::OP_FIRST: rd_idx = '0;
            alc_pkg::OP_NEXT:  rd_idx = cur_plus[IDX_W-1:0];
            default:           rd_idx = cur_idx_reg;
        endcase
    end

    assign rd_word = cell_q[rd_idx];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            alc_pkg::cell_ctl_t   ctl;
            logic [WORD_BITS-1:0] upper;

            if (i + 1 < DEPTH)
            begin : g_up
                assign upper = cell_q[i + 1];
            end
            else
            begin : g_top
                assign upper = '0;
            end

            assign ctl.load  = ins_ok && (count_reg == CNT_W'(i));
            assign ctl.shift = rem_ok && (IDX_W'(i) >= cur_idx_reg)
                               && (CNT_W'(i + 1) < count_reg);

            alc_cell #(
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .data_in (data_in),
                .upper   (upper),
                .q       (cell_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_idx_next   = cur_idx_reg;
        data_out_next  = '0;
        status_next    = alc_pkg::ST_OK;
        unique case (operation)
            alc_pkg::OP_INSERT:
            begin
                if (ins_ok)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    status_next = alc_pkg::ST_FULL;
                end
            end
            alc_pkg::OP_FIRST:
            begin
                if (count_reg == '0)
                begin
                    status_next = alc_pkg::ST_END;
                end
                else
                begin
                    cur_valid_next = 1'b1;
                    cur_idx_next   = '0;
                    data_out_next  = rd_word;
                end
            end
            alc_pkg::OP_NEXT:
            begin
                if (cur_plus >= count_reg)
                begin
                    status_next = alc_pkg::ST_END;
                end
                else
                begin
                    cur_valid_next = 1'b1;
                    cur_idx_next   = cur_plus[IDX_W-1:0];
                    data_out_next  = rd_word;
                end
            end
            default:
            begin
                // cursor always lies below the count when valid
                if (!cur_valid_reg)
                begin
                    status_next = alc_pkg::ST_NOCUR;
                end
                else
                begin
                    data_out_next = rd_word;
                    count_next    = count_reg - CNT_W'(1);
                    if (cur_idx_reg == '0)
                    begin
                        cur_valid_next = 1'b0;
                    end
                    else
                    begin
                        cur_idx_next = cur_idx_reg - IDX_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= req;
            if (req)
            begin
                count_reg     <= count_next;
                cur_valid_reg <= cur_valid_next;
                cur_idx_reg   <= cur_idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req)
        begin
            data_out_reg <= data_out_next;
            status_reg   <= status_next;
        end
    end

    assign done        = done_reg;
    assign data_out    = data_out_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

endmodule

[dv/tb_array_list_with_cursor.sv]
module tb_array_list_with_cursor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = alc_pkg::DEPTH_DEF;
    localparam int W          = alc_pkg::WORD_BITS_DEF;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CYCLE_CAP  = 200000;
    localparam int RAND_REQS  = 640;
    localparam int DIR_ROWS   = 25;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } traffic_mode_t;

    typedef struct packed {
        logic signed [W-1:0] word;
        logic [1:0]          st;
        logic [CNT_W-1:0]    cnt;
    } list_res_t;

    typedef struct packed {
        logic [1:0]     op;
        logic [W-1:0]   word;
        bit             typed;
        list_res_t      res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          operation = alc_pkg::OP_INSERT;
    logic signed [W-1:0] data_in = '0;
    logic                busy;
    logic                done;
    logic signed [W-1:0] data_out;
    logic [1:0]          status;
    logic [CNT_W-1:0]    entry_count;

    // shadow copy of the list
    logic signed [W-1:0] shadow_words [DEPTH];
    int                  shadow_cnt = 0;
    int                  shadow_cur = -1;

    list_res_t           pending_results [$];
    int                  errors = 0;
    int                  cycles = 0;
    int                  burst_left = 0;
    traffic_mode_t       mode = MODE_GROW;
    int                  n_reqs = 0;
    int                  n_full = 0;
    int                  n_end = 0;
    int                  n_nocur = 0;
    int                  n_removed = 0;
    int                  peak_cnt = 0;

    // typed rows carry their expected result here; the others are checked against the shadow copy
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{alc_pkg::OP_FIRST,  32'h0,        1'b1, '{32'h0, alc_pkg::ST_END,   7'd0}},
        '{alc_pkg::OP_NEXT,   32'h0,        1'b1, '{32'h0, alc_pkg::ST_END,   7'd0}},
        '{alc_pkg::OP_REMOVE, 32'h0,        1'b1, '{32'h0, alc_pkg::ST_NOCUR, 7'd0}},
        '{alc_pkg::OP_INSERT, 32'h7fffffff, 1'b1, '{32'h0, alc_pkg::ST_OK,    7'd1}},
        '{alc_pkg::OP_INSERT, 32'h80000000, 1'b1, '{32'h0, alc_pkg::ST_OK,    7'd2}},
        '{alc_pkg::OP_INSERT, 32'h00000000, 1'b1, '{32'h0, alc_pkg::ST_OK,    7'd3}},
        '{alc_pkg::OP_INSERT, 32'hffffffff, 1'b1, '{32'h0, alc_pkg::ST_OK,    7'd4}},
        '{alc_pkg::OP_REMOVE, 32'hffffffff, 1'b1, '{32'h0, alc_pkg::ST_NOCUR, 7'd4}},
        '{alc_pkg::OP_FIRST,  32'h0, 1'b1, '{32'h7fffffff, alc_pkg::ST_OK, 7'd4}},
        '{alc_pkg::OP_NEXT,   32'h0, 1'b1, '{32'h80000000, alc_pkg::ST_OK, 7'd4}},
        '{alc_pkg::OP_NEXT,   32'h0, 1'b1, '{32'h00000000, alc_pkg::ST_OK, 7'd4}},
        '{alc_pkg::OP_NEXT,   32'h0, 1'b1, '{32'hffffffff, alc_pkg::ST_OK, 7'd4}},
        '{alc_pkg::OP_NEXT,   32'h0,        1'b1, '{32'h0, alc_pkg::ST_END,   7'd4}},
        '{alc_pkg::OP_REMOVE, 32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_REMOVE, 32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_REMOVE, 32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_REMOVE, 32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_REMOVE, 32'h0,        1'b1, '{32'h0, alc_pkg::ST_NOCUR, 7'd0}},
        '{alc_pkg::OP_INSERT, 32'h55555555, 1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_INSERT, 32'haaaaaaaa, 1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_FIRST,  32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        // removing entry 0 drops the cursor, so next reads the new head
        '{alc_pkg::OP_REMOVE, 32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_NEXT,   32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_FIRST,  32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}},
        '{alc_pkg::OP_NEXT,   32'h0,        1'b0, '{32'h0, alc_pkg::ST_OK,    7'd0}}
    };

    array_list_with_cursor u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .data_in     (data_in),
        .done        (done),
        .data_out    (data_out),
        .status      (status),
        .entry_count (entry_count)
    );

    always #5 clk = ~clk;

    function automatic list_res_t list_apply(logic [1:0] op, logic signed [W-1:0] word);
        list_res_t r;
        r.word = '0;
        r.st   = alc_pkg::ST_OK;
        case (op)
            alc_pkg::OP_INSERT:
                if (shadow_cnt >= DEPTH)
                begin
                    r.st = alc_pkg::ST_FULL;
                end
                else
                begin
                    shadow_words[shadow_cnt] = word;
                    shadow_cnt++;
                end
            alc_pkg::OP_FIRST:
                if (shadow_cnt == 0)
                begin
                    r.st = alc_pkg::ST_END;
                end
                else
                begin
                    shadow_cur = 0;
                    r.word     = shadow_words[0];
                end
            alc_pkg::OP_NEXT:
                if (shadow_cur >= shadow_cnt - 1)
                begin
                    r.st = alc_pkg::ST_END;
                end
                else
                begin
                    shadow_cur++;
                    r.word = shadow_words[shadow_cur];
                end
            default:
                if (shadow_cur < 0 || shadow_cur >= shadow_cnt)
                begin
                    r.st = alc_pkg::ST_NOCUR;
                end
                else
                begin
                    r.word = shadow_words[shadow_cur];
                    for (int i = shadow_cur; i + 1 < shadow_cnt; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_cnt--;
                    shadow_cur--;
                end
        endcase
        r.cnt = shadow_cnt[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return {1'b0, {(W-1){1'b1}}};
            1:       return {1'b1, {(W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_op(traffic_mode_t m);
        int r;
        r = $urandom_range(0, 99);
        case (m)
            MODE_GROW:
                return (r < 70) ? alc_pkg::OP_INSERT : (r < 80) ? alc_pkg::OP_FIRST :
                       (r < 92) ? alc_pkg::OP_NEXT : alc_pkg::OP_REMOVE;
            MODE_SHRINK:
                return (r < 15) ? alc_pkg::OP_INSERT : (r < 30) ? alc_pkg::OP_FIRST :
                       (r < 65) ? alc_pkg::OP_NEXT : alc_pkg::OP_REMOVE;
            default:
                return r[1:0];
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // present one request and hold it until it is taken
    task automatic issue(logic [1:0] op, logic signed [W-1:0] word, bit typed,
                         list_res_t typed_res);
        list_res_t r;
        start     <= 1'b1;
        operation <= op;
        data_in   <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = list_apply(op, word);
        n_reqs++;
        case (r.st)
            alc_pkg::ST_FULL:  n_full++;
            alc_pkg::ST_END:   n_end++;
            alc_pkg::ST_NOCUR: n_nocur++;
            default:           if (op == alc_pkg::OP_REMOVE) n_removed++;
        endcase
        if (shadow_cnt > peak_cnt)
            peak_cnt = shadow_cnt;
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // bursts of back-to-back requests separated by random gaps (sometimes none); each burst picks a traffic mode
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        mode = traffic_mode_t'($urandom_range(0, 2));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        list_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("[%0t] result with no request outstanding", $realtime);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (data_out !== want.word)
                    report_mismatch("data_out", data_out, want.word);
                if (status !== want.st)
                    report_mismatch("status", W'(status), W'(want.st));
                if (entry_count !== want.cnt)
                    report_mismatch("entry_count", W'(entry_count), W'(want.cnt));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[k])
        begin
            issue(dir_tab[k].op, dir_tab[k].word, dir_tab[k].typed, dir_tab[k].res);
            pace();
        end
        drain();

        // fill to capacity, overrun, walk the whole list, trim the tail
        while (shadow_cnt < DEPTH + 3)
        begin
            issue(alc_pkg::OP_INSERT, pick_word(), 1'b0, '0);
            pace();
            if (shadow_cnt == DEPTH && n_full >= 3)
                break;
        end
        issue(alc_pkg::OP_FIRST, '0, 1'b0, '0);
        repeat (DEPTH)
        begin
            issue(alc_pkg::OP_NEXT, pick_word(), 1'b0, '0);
            pace();
        end
        repeat (4)
        begin
            issue(alc_pkg::OP_REMOVE, pick_word(), 1'b0, '0);
            pace();
        end
        drain();

        repeat (RAND_REQS)
        begin
            issue(pick_op(mode), pick_word(), 1'b0, '0);
            pace();
        end
        drain();
        repeat (4) @(posedge clk);

        $display("run covered %0d requests: %0d removes, %0d full, %0d at end, %0d no cursor",
                 n_reqs, n_removed, n_full, n_end, n_nocur);
        $display("list held up to %0d of %0d entries", peak_cnt, DEPTH);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[array_list_with_cursor.f]
rtl/alc_pkg.sv
rtl/alc_cell.sv
rtl/array_list_with_cursor.sv
dv/tb_array_list_with_cursor.sv
